/* rtl/bqblc_pkg.sv */
package bqblc_pkg;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 24;
	localparam int COEF_BITS      = 28;
	localparam int STATE_BITS     = 40;
	localparam int GUARD_BITS     = 8;
	localparam int NUM_SECTIONS   = 3;
	localparam int NUM_REGS       = 8;
	localparam int COEF_IDX_BITS  = $clog2(NUM_REGS);
	localparam int CFG_IDX_BITS   = 4;
	localparam int SEC_BITS       = $clog2(NUM_SECTIONS);
	localparam int LAST_STEP      = 16;
	localparam int STEP_BITS      = $clog2(LAST_STEP + 1);

	// datapath widths
	localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
	localparam int DIFF_BITS = PROD_BITS + 1;
	localparam int RND_SH    = COEF_FRAC_BITS - GUARD_BITS;
	localparam int RP_BITS   = PROD_BITS + 1 - RND_SH;
	localparam int RD_BITS   = DIFF_BITS + 1 - RND_SH;
	localparam int ACC_BITS  = imax(RP_BITS, STATE_BITS) + 1;
	localparam int YV_BITS   = ACC_BITS + 1 - GUARD_BITS;
	localparam int FDS_BITS  = imax(RD_BITS, STATE_BITS) + 1;
	localparam int SDS_BITS  = imax(RD_BITS, STATE_BITS);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [STATE_BITS-1:0]  delay_t;

	localparam logic [PROD_BITS:0] PR_HALF = (PROD_BITS + 1)'(1) << (RND_SH - 1);
	localparam logic [DIFF_BITS:0] D_HALF  = (DIFF_BITS + 1)'(1) << (RND_SH - 1);
	localparam logic [ACC_BITS:0]  Y_HALF  = (ACC_BITS + 1)'(1) << (GUARD_BITS - 1);

	localparam logic signed [YV_BITS-1:0] Y_MAX =
		YV_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [YV_BITS-1:0] Y_MIN = ~Y_MAX;
	localparam logic signed [FDS_BITS-1:0] F_MAX =
		FDS_BITS'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
	localparam logic signed [FDS_BITS-1:0] F_MIN = ~F_MAX;
	localparam logic signed [SDS_BITS-1:0] S_MAX =
		SDS_BITS'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
	localparam logic signed [SDS_BITS-1:0] S_MIN = ~S_MAX;

	localparam coef_t COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

	typedef enum logic {
		OP_FILTER = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// low bits of the register index; the top bit picks the low-pass set
	typedef enum logic [1:0] {
		CF_B0 = 2'd0,
		CF_B1 = 2'd1,
		CF_A1 = 2'd2,
		CF_A2 = 2'd3
	} coef_sel_t;

	typedef struct packed {
		logic                set_lp;
		coef_sel_t           coef;
		logic                src_x;
		logic                acc_en;
		logic [SEC_BITS-1:0] acc_sec;
		logic                y_en;
		logic                bx1_en;
		logic                d_en;
		logic                d_from_b0;
		logic                fd_en;
		logic                sd_en;
		logic [SEC_BITS-1:0] upd_sec;
		logic                load;
		logic                hist_clr;
		logic                out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clipped;
		logic                          block_end;
	} result_t;

	// Fixed schedule: a section's state update overlaps the next section's
	// first two multiplies.
	function automatic dp_cmd_t mc_decode(input logic [STEP_BITS-1:0] step);
		dp_cmd_t c;
		c = '0;
		unique case (step)
			0: begin
				c.coef  = CF_B0;
				c.src_x = 1'b1;
			end
			1: begin
				c.coef    = CF_B1;
				c.src_x   = 1'b1;
				c.acc_en  = 1'b1;
				c.acc_sec = SEC_BITS'(0);
			end
			2, 7, 12: begin
				c.y_en   = 1'b1;
				c.bx1_en = 1'b1;
			end
			3, 8: c.coef = CF_A1;
			4, 9: begin
				c.coef = CF_A2;
				c.d_en = 1'b1;
			end
			5: begin
				c.fd_en     = 1'b1;
				c.upd_sec   = SEC_BITS'(0);
				c.d_en      = 1'b1;
				c.d_from_b0 = 1'b1;
				c.coef      = CF_B0;
			end
			6: begin
				c.sd_en   = 1'b1;
				c.upd_sec = SEC_BITS'(0);
				c.coef    = CF_B1;
				c.acc_en  = 1'b1;
				c.acc_sec = SEC_BITS'(1);
			end
			10: begin
				c.fd_en     = 1'b1;
				c.upd_sec   = SEC_BITS'(1);
				c.d_en      = 1'b1;
				c.d_from_b0 = 1'b1;
				c.coef      = CF_B0;
				c.set_lp    = 1'b1;
			end
			11: begin
				c.sd_en   = 1'b1;
				c.upd_sec = SEC_BITS'(1);
				c.coef    = CF_B1;
				c.set_lp  = 1'b1;
				c.acc_en  = 1'b1;
				c.acc_sec = SEC_BITS'(2);
			end
			13: begin
				c.coef   = CF_A1;
				c.set_lp = 1'b1;
			end
			14: begin
				c.coef   = CF_A2;
				c.set_lp = 1'b1;
				c.d_en   = 1'b1;
			end
			15: begin
				c.fd_en     = 1'b1;
				c.upd_sec   = SEC_BITS'(2);
				c.d_en      = 1'b1;
				c.d_from_b0 = 1'b1;
			end
			16: begin
				c.sd_en   = 1'b1;
				c.upd_sec = SEC_BITS'(2);
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/bqblc_if.sv */
interface bqblc_in_if;
	import bqblc_pkg::*;
	logic    valid;
	logic    ready;
	logic    operation;
	sample_t sample_in;
	logic    block_end_in;
	modport source(output valid, operation, sample_in, block_end_in, input ready);
	modport sink(input valid, operation, sample_in, block_end_in, output ready);
endinterface

interface bqblc_out_if;
	import bqblc_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_out;
	logic    clipped;
	logic    block_end_out;
	modport source(output valid, sample_out, clipped, block_end_out, input ready);
	modport sink(input valid, sample_out, clipped, block_end_out, output ready);
endinterface

interface bqblc_cfg_if;
	import bqblc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	coef_t                   data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/bqblc_ctrl.sv */
module bqblc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	output bqblc_pkg::dp_cmd_t cmd
);
	import bqblc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} fsm_t;

	fsm_t                 state_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 last;
	logic                 done_now;
	logic                 acc_in;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		last     = (step_q == STEP_BITS'(LAST_STEP));
		done_now = ((state_q == ST_RUN) && last) || (state_q == ST_WAIT);
		in_ready = (state_q == ST_IDLE) || (done_now && out_free);
		acc_in   = in_valid && in_ready;
		cmd      = (state_q == ST_RUN) ? mc_decode(step_q) : '0;
		cmd.load     = acc_in && (in_op == OP_FILTER);
		cmd.hist_clr = acc_in && (in_op == OP_CLEAR);
		cmd.out_load = done_now && out_free;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!last) begin
						step_q <= step_q + STEP_BITS'(1);
					end else if (out_free) begin
						step_q  <= '0;
						state_q <= cmd.load ? ST_RUN : ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					step_q <= '0;
					if (out_free) begin
						state_q <= cmd.load ? ST_RUN : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/bqblc_dp.sv */
module bqblc_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bqblc_pkg::dp_cmd_t                    cmd,
	input  logic signed [bqblc_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                  block_end_in,
	bqblc_cfg_if.sink                             cfg,
	output bqblc_pkg::result_t                    res
);
	import bqblc_pkg::*;

	coef_t  coef_q [NUM_REGS];
	delay_t fd_q   [NUM_SECTIONS];
	delay_t sd_q   [NUM_SECTIONS];

	sample_t                     x_q;
	sample_t                     y_q;
	logic                        be_q;
	logic                        clip_q;
	logic signed [PROD_BITS-1:0] prod_q;
	logic signed [PROD_BITS-1:0] bx0_q;
	logic signed [PROD_BITS-1:0] bx1_q;
	logic signed [DIFF_BITS-1:0] d_q;
	logic signed [ACC_BITS-1:0]  acc_q;
	result_t                     res_q;

	coef_t                       mul_c;
	sample_t                     mul_x;
	logic [PROD_BITS:0]          pr_sum;
	logic signed [RP_BITS-1:0]   pr_rnd;
	logic signed [ACC_BITS-1:0]  acc_d;
	logic [ACC_BITS:0]           y_sum;
	logic signed [YV_BITS-1:0]   yv;
	sample_t                     y_sat;
	logic                        y_clip;
	logic [DIFF_BITS:0]          d_sum;
	logic signed [RD_BITS-1:0]   d_rnd;
	logic signed [FDS_BITS-1:0]  fd_sum;
	delay_t                      fd_sat;
	logic                        fd_clip;
	logic signed [SDS_BITS-1:0]  sd_ext;
	delay_t                      sd_sat;
	logic                        sd_clip;
	logic                        cfg_wr;
	logic                        hist_clear;
	logic                        clip_d;

	assign cfg.ready  = 1'b1;
	assign cfg_wr     = cfg.valid && (cfg.index < CFG_IDX_BITS'(NUM_REGS));
	assign hist_clear = cmd.hist_clr || cfg_wr;
	assign res        = res_q;

	always_comb begin
		mul_c = coef_q[{cmd.set_lp, cmd.coef}];
		mul_x = cmd.src_x ? x_q : y_q;

		// b0*x rounded to delay format, plus first delay
		pr_sum = (PROD_BITS + 1)'(prod_q) + PR_HALF;
		pr_rnd = $signed(pr_sum[PROD_BITS:RND_SH]);
		acc_d  = ACC_BITS'(pr_rnd) + ACC_BITS'(fd_q[cmd.acc_sec]);

		y_sum  = (ACC_BITS + 1)'(acc_q) + Y_HALF;
		yv     = $signed(y_sum[ACC_BITS:GUARD_BITS]);
		y_clip = 1'b0;
		y_sat  = SAMPLE_BITS'(yv);
		if (yv > Y_MAX) begin
			y_sat  = SAMPLE_BITS'(Y_MAX);
			y_clip = 1'b1;
		end else if (yv < Y_MIN) begin
			y_sat  = SAMPLE_BITS'(Y_MIN);
			y_clip = 1'b1;
		end

		// one rounder serves both delay updates
		d_sum = (DIFF_BITS + 1)'(d_q) + D_HALF;
		d_rnd = $signed(d_sum[DIFF_BITS:RND_SH]);

		fd_sum  = FDS_BITS'(d_rnd) + FDS_BITS'(sd_q[cmd.upd_sec]);
		fd_clip = 1'b0;
		fd_sat  = STATE_BITS'(fd_sum);
		if (fd_sum > F_MAX) begin
			fd_sat  = STATE_BITS'(F_MAX);
			fd_clip = 1'b1;
		end else if (fd_sum < F_MIN) begin
			fd_sat  = STATE_BITS'(F_MIN);
			fd_clip = 1'b1;
		end

		sd_ext  = SDS_BITS'(d_rnd);
		sd_clip = 1'b0;
		sd_sat  = STATE_BITS'(sd_ext);
		if (sd_ext > S_MAX) begin
			sd_sat  = STATE_BITS'(S_MAX);
			sd_clip = 1'b1;
		end else if (sd_ext < S_MIN) begin
			sd_sat  = STATE_BITS'(S_MIN);
			sd_clip = 1'b1;
		end

		clip_d = clip_q | (cmd.y_en & y_clip) | (cmd.fd_en & fd_clip) | (cmd.sd_en & sd_clip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= (coef_sel_t'(i[1:0]) == CF_B0) ? COEF_ONE : '0;
			end
			for (int k = 0; k < NUM_SECTIONS; k++) begin
				fd_q[k] <= '0;
				sd_q[k] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				coef_q[cfg.index[COEF_IDX_BITS-1:0]] <= cfg.data;
			end
			if (hist_clear) begin
				for (int k = 0; k < NUM_SECTIONS; k++) begin
					fd_q[k] <= '0;
					sd_q[k] <= '0;
				end
			end else begin
				if (cmd.fd_en) begin
					fd_q[cmd.upd_sec] <= fd_sat;
				end
				if (cmd.sd_en) begin
					sd_q[cmd.upd_sec] <= sd_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(mul_c) * PROD_BITS'(mul_x);
		clip_q <= cmd.load ? 1'b0 : clip_d;
		if (cmd.load) begin
			x_q  <= sample_in;
			be_q <= block_end_in;
		end
		if (cmd.acc_en) begin
			bx0_q <= prod_q;
			acc_q <= acc_d;
		end
		if (cmd.y_en) begin
			y_q <= y_sat;
		end
		if (cmd.bx1_en) begin
			bx1_q <= prod_q;
		end
		if (cmd.d_en) begin
			d_q <= (cmd.d_from_b0 ? DIFF_BITS'(bx0_q) : DIFF_BITS'(bx1_q)) - DIFF_BITS'(prod_q);
		end
		if (cmd.out_load) begin
			res_q <= '{sample: y_q, clipped: clip_d, block_end: be_q};
		end
	end

endmodule

/* rtl/biquad_band_limit_cascade_top.sv */
// Channel   Dir  Payload                                    Transfer
// samples   in   operation, sample_in, block_end_in         valid & ready
// results   out  sample_out, clipped, block_end_out         valid & ready
// cfg       in   index (8 coefficient registers), data      valid & ready
//
// A filter sample runs from transfer to registered result on a fixed 17-step
// schedule: one shared 28x24 multiplier works through twelve products.
// A clear transfer zeroes the filter history and gives no result.
// The next sample is taken in the cycle the current one completes, unless the
// result register is full and not being read; a stalled result holds the block.
// Reset: history zero, b0 of both sets 1.0, other coefficients zero.
module biquad_band_limit_cascade_top (
	input  logic        clk,
	input  logic        arst_n,
	bqblc_in_if.sink    samples,
	bqblc_out_if.source results,
	bqblc_cfg_if.sink   cfg
);
	import bqblc_pkg::*;

	dp_cmd_t cmd;
	result_t res;
	logic    in_ready;
	logic    out_valid;

	bqblc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_op     (samples.operation),
		.in_ready  (in_ready),
		.out_ready (results.ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	bqblc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample_in    (samples.sample_in),
		.block_end_in (samples.block_end_in),
		.cfg          (cfg),
		.res          (res)
	);

	assign samples.ready         = in_ready;
	assign results.valid         = out_valid;
	assign results.sample_out    = res.sample;
	assign results.clipped       = res.clipped;
	assign results.block_end_out = res.block_end;

	a_upd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fd_en && cmd.sd_en))
		else $error("both delay updates in one cycle");

	a_no_rw_same_sec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_en && (cmd.fd_en || cmd.sd_en)) |-> (cmd.acc_sec != cmd.upd_sec))
		else $error("delay read and update of one section in one cycle");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !cmd.out_load)
		else $error("result loaded right after sample transfer");

	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hist_clr && !cmd.out_load && !results.valid) |=> !results.valid)
		else $error("clear produced a result");

endmodule
